/* src/nfccrc_pkg.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfccrc_pkg
// Shared types and constants of the NFC RF CRC-16 engine: request payloads,
// CRC mode codes, polynomials, initial values and the result sequencer phases.
// ----------------------------------------------------------------------------
package nfccrc_pkg;

	// crc mode codes
	localparam logic [1:0] MODE_A = 2'd0;
	localparam logic [1:0] MODE_B = 2'd1;
	localparam logic [1:0] MODE_F = 2'd2;

	// polynomials, initial values and final xor
	localparam logic [15:0] POLY_REFL = 16'h8408;
	localparam logic [15:0] POLY_MSB  = 16'h1021;
	localparam logic [15:0] INIT_A    = 16'h6363;
	localparam logic [15:0] INIT_B    = 16'hFFFF;
	localparam logic [15:0] INIT_F    = 16'h0000;
	localparam logic [15:0] XOR_B     = 16'hFFFF;
	localparam logic [15:0] TOP_BIT   = 16'h8000;

	// input request
	typedef struct packed {
		logic [7:0] data_byte;
		logic       frame_end;
	} in_item_t;

	// result request
	typedef struct packed {
		logic [7:0]  out_byte;
		logic        is_crc_byte;
		logic [15:0] crc_value;
		logic        last_of_run;
	} out_item_t;

	// finalized crc and its two bytes in transmit order
	typedef struct packed {
		logic [15:0] fin;
		logic [7:0]  first_byte;
		logic [7:0]  second_byte;
	} crc_res_t;

	// result sequencer phase
	typedef enum logic [1:0] {
		PH_ECHO,
		PH_CRC1,
		PH_CRC2
	} phase_t;

	// initial crc register value of a mode
	function automatic logic [15:0] mode_init(input logic [1:0] mode);
		logic [15:0] v;
		case (mode)
			MODE_A:  v = INIT_A;
			MODE_B:  v = INIT_B;
			default: v = INIT_F;
		endcase
		return v;
	endfunction

endpackage

/* src/nfccrc_crc_unit.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfccrc_crc_unit
// Mode register and running CRC-16 register. Folds one byte per step with an
// unrolled 8-bit update, finalizes the result and reloads on frame end.
// ----------------------------------------------------------------------------
module nfccrc_crc_unit (
	input  logic                clk,
	input  logic                arst_n,
	input  logic                cfg_we,
	input  logic [1:0]          cfg_wdata,
	input  logic                step,
	input  logic [7:0]          data_byte,
	input  logic                frame_end,
	output nfccrc_pkg::crc_res_t res
);

	logic [1:0]  mode_q;
	logic [15:0] running_crc_q;
	logic [15:0] crc_next;
	logic [15:0] fin;
	logic        refl;

	// reflected modes share the 0x8408 update
	always_comb begin
		case (mode_q) inside
			nfccrc_pkg::MODE_A, nfccrc_pkg::MODE_B: refl = 1'b1;
			default:                                refl = 1'b0;
		endcase
	end

	// unrolled byte update
	always_comb begin
		logic [15:0] c;
		if (refl) begin
			c = running_crc_q ^ {8'h00, data_byte};
			for (int b = 0; b < 8; b++) begin
				c = c[0] ? ((c >> 1) ^ nfccrc_pkg::POLY_REFL) : (c >> 1);
			end
		end else begin
			c = running_crc_q ^ {data_byte, 8'h00};
			for (int b = 0; b < 8; b++) begin
				c = (c & nfccrc_pkg::TOP_BIT) != 16'h0000
					? ((c << 1) ^ nfccrc_pkg::POLY_MSB) : (c << 1);
			end
		end
		crc_next = c;
	end

	// final xor and byte order
	always_comb begin
		fin = (mode_q == nfccrc_pkg::MODE_B) ? (crc_next ^ nfccrc_pkg::XOR_B) : crc_next;
		res.fin = fin;
		if (refl) begin
			res.first_byte  = fin[7:0];
			res.second_byte = fin[15:8];
		end else begin
			res.first_byte  = fin[15:8];
			res.second_byte = fin[7:0];
		end
	end

	// mode and running crc registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			mode_q        <= nfccrc_pkg::MODE_A;
			running_crc_q <= nfccrc_pkg::INIT_A;
		end else if (cfg_we) begin
			mode_q        <= cfg_wdata;
			running_crc_q <= nfccrc_pkg::mode_init(cfg_wdata);
		end else if (step) begin
			running_crc_q <= frame_end ? nfccrc_pkg::mode_init(mode_q) : crc_next;
		end
	end

endmodule

/* src/nfccrc_out_seq.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfccrc_out_seq
// Result register. Holds the echo result of a byte and, after a frame's last
// byte, steps through the two appended CRC byte results.
// ----------------------------------------------------------------------------
module nfccrc_out_seq (
	input  logic                 clk,
	input  logic                 arst_n,
	input  logic                 item_valid,
	input  logic [7:0]           data_byte,
	input  logic                 frame_end,
	input  nfccrc_pkg::crc_res_t res,
	output logic                 take,
	output logic                 out_valid,
	input  logic                 out_ready,
	output nfccrc_pkg::out_item_t out_data
);

	nfccrc_pkg::phase_t    phase_q;
	nfccrc_pkg::phase_t    phase_d;
	nfccrc_pkg::out_item_t out_q;
	nfccrc_pkg::out_item_t out_d;
	logic                  out_valid_q;
	logic                  out_valid_d;
	logic [7:0]            first_q;
	logic [7:0]            second_q;
	logic                  load;
	logic                  pop_mid;

	// free when empty or when the final result of a run leaves
	assign take    = !out_valid_q || (out_ready && out_q.last_of_run);
	assign load    = item_valid && take;
	assign pop_mid = out_valid_q && out_ready && !out_q.last_of_run;

	// next phase
	always_comb begin
		phase_d = phase_q;
		case (phase_q)
			nfccrc_pkg::PH_ECHO: if (pop_mid) phase_d = nfccrc_pkg::PH_CRC1;
			nfccrc_pkg::PH_CRC1: if (pop_mid) phase_d = nfccrc_pkg::PH_CRC2;
			default:             phase_d = phase_q;
		endcase
		if (load) phase_d = nfccrc_pkg::PH_ECHO;
	end

	// next result
	always_comb begin
		out_d       = out_q;
		out_valid_d = out_valid_q;
		if (load) begin
			out_d.out_byte    = data_byte;
			out_d.is_crc_byte = 1'b0;
			out_d.crc_value   = res.fin;
			out_d.last_of_run = !frame_end;
			out_valid_d       = 1'b1;
		end else if (pop_mid) begin
			out_d.is_crc_byte = 1'b1;
			case (phase_q)
				nfccrc_pkg::PH_ECHO: begin
					out_d.out_byte    = first_q;
					out_d.last_of_run = 1'b0;
				end
				default: begin
					out_d.out_byte    = second_q;
					out_d.last_of_run = 1'b1;
				end
			endcase
		end else if (out_valid_q && out_ready) begin
			out_valid_d = 1'b0;
		end
	end

	// control registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			phase_q     <= nfccrc_pkg::PH_ECHO;
			out_valid_q <= 1'b0;
		end else begin
			phase_q     <= phase_d;
			out_valid_q <= out_valid_d;
		end
	end

	// payload registers
	always_ff @(posedge clk) begin
		out_q <= out_d;
		if (load) begin
			first_q  <= res.first_byte;
			second_q <= res.second_byte;
		end
	end

	assign out_valid = out_valid_q;
	assign out_data  = out_q;

	// echo of a last byte is followed by the first crc byte
	a_echo_to_crc1: assert property (@(posedge clk) disable iff (!arst_n)
		(pop_mid && phase_q == nfccrc_pkg::PH_ECHO)
		|=> (out_valid_q && phase_q == nfccrc_pkg::PH_CRC1))
		else $error("first crc byte did not follow echo");

	// first crc byte is a crc byte and not the end of the run
	a_crc1_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && phase_q == nfccrc_pkg::PH_CRC1)
		|-> (out_q.is_crc_byte && !out_q.last_of_run))
		else $error("bad first crc byte result");

	// second crc byte closes the run
	a_crc2_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && phase_q == nfccrc_pkg::PH_CRC2)
		|-> (out_q.is_crc_byte && out_q.last_of_run))
		else $error("bad second crc byte result");

	// echo results never carry the crc mark
	a_echo_shape: assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && phase_q == nfccrc_pkg::PH_ECHO) |-> !out_q.is_crc_byte)
		else $error("echo result marked as crc byte");

endmodule

/* src/nfc_rf_crc16_engine_core.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// nfc_rf_crc16_engine_core
// Multi-mode CRC-16 engine for NFC RF frames (CRC-A, CRC-B/ISO 15693, FeliCa).
// ----------------------------------------------------------------------------
// Usage:
//   in_valid/in_ready carry one frame byte per request, frame_end on the last.
//   out_valid/out_ready carry results: every byte is echoed with the finalized
//   crc so far; after a frame's last byte two crc byte results follow (low
//   byte first for CRC-A/B, high byte first for FeliCa). last_of_run marks the
//   final result caused by an input request.
//   cfg_we/cfg_wdata write crc_mode and reload the crc register;
//   write it only while the engine is idle.
// Timing:
//   an accepted byte is registered in the input register, then in the result
//   register, which presents its echo result. Throughput is one byte per cycle
//   while out_ready is high, set by the combinational 8-bit crc update; a
//   frame-end byte holds the result register until its three results leave.
// Reset:
//   arst_n clears all requests in flight and sets CRC-A mode, crc 0x6363.
// Stall:
//   when out_ready is low the result holds, the input register fills and
//   in_ready drops; no request is lost.
// ----------------------------------------------------------------------------
module nfc_rf_crc16_engine_core (
	input  logic                  clk,
	input  logic                  arst_n,
	input  logic                  in_valid,
	output logic                  in_ready,
	input  nfccrc_pkg::in_item_t  in_data,
	output logic                  out_valid,
	input  logic                  out_ready,
	output nfccrc_pkg::out_item_t out_data,
	input  logic                  cfg_we,
	input  logic [1:0]            cfg_wdata
);

	logic                 valid_s1;
	nfccrc_pkg::in_item_t item_s1;
	logic                 take;
	logic                 adv;
	nfccrc_pkg::crc_res_t res;

	// input register advances when the result register takes it
	assign adv      = valid_s1 && take;
	assign in_ready = !valid_s1 || adv;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_data;
		end
	end

	// crc register and update
	nfccrc_crc_unit u_crc (
		.clk       (clk),
		.arst_n    (arst_n),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata),
		.step      (adv),
		.data_byte (item_s1.data_byte),
		.frame_end (item_s1.frame_end),
		.res       (res)
	);

	// result register and crc byte sequencing
	nfccrc_out_seq u_seq (
		.clk        (clk),
		.arst_n     (arst_n),
		.item_valid (valid_s1),
		.data_byte  (item_s1.data_byte),
		.frame_end  (item_s1.frame_end),
		.res        (res),
		.take       (take),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_data   (out_data)
	);

endmodule

/* test/testbench.sv */
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench
// Self-checking bench for the NFC RF CRC-16 engine. A short table of frames
// covers reset state, byte extremes, every crc mode (including the unused mode
// code), and mode writes in the middle of a frame. Known check values are
// written into the table. Random frames in all modes then follow, with random
// gaps and stalls on both handshakes and one long output hold-off. A local crc
// model predicts every echo and crc byte, and the bench compares each result
// field by field in order.
// ----------------------------------------------------------------------------
module testbench;
	import nfccrc_pkg::*;

	localparam int          DIRECTED_ROWS = 20;
	localparam int          RANDOM_ITEMS  = 450;
	localparam int          MAX_GAP       = 15;
	localparam int          SETTLE_CYCLES = 6;
	localparam int          PRESSURE_AT   = 200;
	localparam int          HOLD_CYCLES   = 300;
	localparam int          STALL_LIMIT   = 2000;
	// undefined mode code, behaves as FeliCa
	localparam logic [1:0]  MODE_ALIAS_F  = 2'd3;

	// one row of the directed frame table
	typedef struct packed {
		bit          wr_mode;
		logic [1:0]  mode;
		logic [7:0]  data;
		logic        last;
		bit          known;
		logic [15:0] crc;
	} frame_row_t;

	logic      clk;
	logic      arst_n;
	logic      in_valid;
	logic      in_ready;
	in_item_t  in_data;
	logic      out_valid;
	logic      out_ready;
	out_item_t out_data;
	logic      cfg_we;
	logic [1:0] cfg_wdata;

	// local copy of the engine state
	logic [1:0]  model_mode;
	logic [15:0] model_crc;
	out_item_t   crc_results_due [$];

	frame_row_t  frame_rows [DIRECTED_ROWS];
	logic [1:0]  mode_cycle [4];
	bit          fast_phase;
	bit          pressure_done;
	int          mismatch_count;
	int          bytes_sent;
	int          frames_sent;
	int          mode_writes;
	int          results_checked;
	int          crc_bytes_checked;
	int          quiet_cycles;

	nfc_rf_crc16_engine_core uut (
		.clk       (clk),
		.arst_n    (arst_n),
		.in_valid  (in_valid),
		.in_ready  (in_ready),
		.in_data   (in_data),
		.out_valid (out_valid),
		.out_ready (out_ready),
		.out_data  (out_data),
		.cfg_we    (cfg_we),
		.cfg_wdata (cfg_wdata)
	);

	// clock
	initial clk = 1'b0;
	always #5 clk = ~clk;

	// initial crc register value of a mode
	function automatic logic [15:0] crc_seed(input logic [1:0] m);
		logic [15:0] v;
		case (m)
			MODE_A:  v = INIT_A;
			MODE_B:  v = INIT_B;
			default: v = INIT_F;
		endcase
		return v;
	endfunction

	// advance the crc register by one byte
	function automatic logic [15:0] crc_fold(input logic [1:0] m, input logic [15:0] c,
		input logic [7:0] b);
		logic [15:0] r;
		int          i;
		r = c;
		if (m == MODE_A || m == MODE_B) begin
			r = r ^ {8'h00, b};
			for (i = 0; i < 8; i++)
				r = r[0] ? ((r >> 1) ^ POLY_REFL) : (r >> 1);
		end else begin
			r = r ^ {b, 8'h00};
			for (i = 0; i < 8; i++)
				r = ((r & TOP_BIT) != 16'h0000) ? ((r << 1) ^ POLY_MSB) : (r << 1);
		end
		return r;
	endfunction

	// finalized crc as sent on the air
	function automatic logic [15:0] crc_finish(input logic [1:0] m, input logic [15:0] c);
		return (m == MODE_B) ? (c ^ XOR_B) : c;
	endfunction

	// queue the echo and, on a frame end, the two crc bytes
	task automatic forecast_byte_results(input in_item_t req, input bit known,
		input logic [15:0] known_crc);
		out_item_t   r;
		logic [15:0] fin;
		model_crc = crc_fold(model_mode, model_crc, req.data_byte);
		fin = known ? known_crc : crc_finish(model_mode, model_crc);
		r.out_byte    = req.data_byte;
		r.is_crc_byte = 1'b0;
		r.crc_value   = fin;
		r.last_of_run = !req.frame_end;
		crc_results_due.push_back(r);
		if (req.frame_end) begin
			r.is_crc_byte = 1'b1;
			r.last_of_run = 1'b0;
			r.out_byte    = (model_mode == MODE_A || model_mode == MODE_B) ? fin[7:0] : fin[15:8];
			crc_results_due.push_back(r);
			r.last_of_run = 1'b1;
			r.out_byte    = (model_mode == MODE_A || model_mode == MODE_B) ? fin[15:8] : fin[7:0];
			crc_results_due.push_back(r);
			model_crc = crc_seed(model_mode);
		end
	endtask

	// offer one frame byte and wait for the handshake
	task automatic offer_byte(input logic [7:0] b, input logic fe, input bit known,
		input logic [15:0] known_crc);
		in_item_t req;
		int       gap;
		gap = fast_phase ? 0 : $urandom_range(0, MAX_GAP);
		req.data_byte = b;
		req.frame_end = fe;
		if (gap > 0) begin
			in_valid <= 1'b0;
			repeat (gap) @(posedge clk);
		end
		in_valid <= 1'b1;
		in_data  <= req;
		do @(posedge clk); while (!in_ready);
		forecast_byte_results(req, known, known_crc);
		bytes_sent++;
	endtask

	// write crc_mode once the engine has drained
	task automatic write_mode(input logic [1:0] m);
		in_valid <= 1'b0;
		while (crc_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		cfg_we    <= 1'b1;
		cfg_wdata <= m;
		@(posedge clk);
		cfg_we     <= 1'b0;
		model_mode = m;
		model_crc  = crc_seed(m);
		mode_writes++;
	endtask

	// stimulus
	initial begin : frame_source
		int         row;
		int         phase;
		int         n_frames;
		int         f;
		int         k;
		int         len;
		bit         cut;
		logic [7:0] b;
		arst_n     = 1'b0;
		in_valid   = 1'b0;
		in_data    = '0;
		cfg_we     = 1'b0;
		cfg_wdata  = MODE_A;
		model_mode = MODE_A;
		model_crc  = INIT_A;
		fast_phase = 1'b0;
		mode_cycle = '{MODE_A, MODE_B, MODE_F, MODE_ALIAS_F};
		// wr_mode, mode, data, last, known, crc
		frame_rows = '{
			'{1'b0, MODE_A,       8'h31, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_A,       8'h32, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_A,       8'h33, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_A,       8'h34, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_A,       8'h35, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_A,       8'h36, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_A,       8'h37, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_A,       8'h38, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_A,       8'h39, 1'b1, 1'b1, 16'hBF05},
			'{1'b0, MODE_A,       8'h00, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_A,       8'h00, 1'b1, 1'b1, 16'h1EA0},
			'{1'b1, MODE_B,       8'hFF, 1'b1, 1'b1, 16'hFF00},
			'{1'b0, MODE_B,       8'h12, 1'b0, 1'b0, 16'h0000},
			// mode write drops the open frame
			'{1'b1, MODE_F,       8'h01, 1'b1, 1'b1, 16'h1021},
			'{1'b1, MODE_ALIAS_F, 8'h01, 1'b1, 1'b1, 16'h1021},
			'{1'b0, MODE_ALIAS_F, 8'h00, 1'b1, 1'b1, 16'h0000},
			'{1'b1, MODE_F,       8'hA5, 1'b0, 1'b0, 16'h0000},
			'{1'b0, MODE_F,       8'hFF, 1'b1, 1'b0, 16'h0000},
			'{1'b1, MODE_A,       8'hFF, 1'b0, 1'b0, 16'h0000},
			'{1'b1, MODE_B,       8'hFF, 1'b1, 1'b1, 16'hFF00}
		};
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		// directed frames
		for (row = 0; row < DIRECTED_ROWS; row++) begin
			if (frame_rows[row].wr_mode)
				write_mode(frame_rows[row].mode);
			offer_byte(frame_rows[row].data, frame_rows[row].last, frame_rows[row].known,
				frame_rows[row].crc);
			if (frame_rows[row].last)
				frames_sent++;
		end

		// random frames, one mode per phase, last frame sometimes left open
		phase = 0;
		while (bytes_sent < DIRECTED_ROWS + RANDOM_ITEMS) begin
			write_mode(mode_cycle[phase % 4]);
			phase++;
			fast_phase = ($urandom_range(0, 3) == 0);
			n_frames = $urandom_range(2, 5);
			for (f = 0; f < n_frames; f++) begin
				len = ($urandom_range(0, 9) == 0) ? $urandom_range(9, 40) : $urandom_range(1, 8);
				cut = (f == n_frames - 1) && ($urandom_range(0, 3) == 0);
				for (k = 0; k < len; k++) begin
					case ($urandom_range(0, 7))
						0:       b = 8'h00;
						1:       b = 8'hFF;
						default: b = 8'($urandom_range(0, 255));
					endcase
					offer_byte(b, (k == len - 1) && !cut, 1'b0, 16'h0000);
				end
				if (!cut)
					frames_sent++;
			end
		end

		// drain and settle
		in_valid <= 1'b0;
		while (crc_results_due.size() != 0) @(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
		$display("covered %0d bytes in %0d closed frames across %0d mode writes",
			bytes_sent, frames_sent, mode_writes);
		$display("checked %0d results, %0d of them appended crc bytes",
			results_checked, crc_bytes_checked);
		if (mismatch_count == 0)
			$display("ALL CHECKS PASSED");
		else
			$display("CHECKS FAILED");
		$finish;
	end

	// result sink with random stalls and one long hold-off
	initial begin : result_sink
		int        stall;
		out_item_t want;
		out_ready         = 1'b0;
		pressure_done     = 1'b0;
		mismatch_count    = 0;
		results_checked   = 0;
		crc_bytes_checked = 0;
		wait (arst_n === 1'b1);
		forever begin
			stall = fast_phase ? 0 : $urandom_range(0, MAX_GAP);
			if (!pressure_done && results_checked >= PRESSURE_AT) begin
				pressure_done = 1'b1;
				stall = HOLD_CYCLES;
			end
			if (stall > 0) begin
				out_ready <= 1'b0;
				repeat (stall) @(posedge clk);
			end
			out_ready <= 1'b1;
			do @(posedge clk); while (!out_valid);
			if (crc_results_due.size() == 0) begin
				$display("%0t: result with nothing pending, got %p", $time, out_data);
				mismatch_count++;
			end else begin
				want = crc_results_due.pop_front();
				if (out_data.out_byte !== want.out_byte) begin
					$display("%0t: out_byte expected %02h got %02h", $time,
						want.out_byte, out_data.out_byte);
					mismatch_count++;
				end
				if (out_data.is_crc_byte !== want.is_crc_byte) begin
					$display("%0t: is_crc_byte expected %0b got %0b", $time,
						want.is_crc_byte, out_data.is_crc_byte);
					mismatch_count++;
				end
				if (out_data.crc_value !== want.crc_value) begin
					$display("%0t: crc_value expected %04h got %04h", $time,
						want.crc_value, out_data.crc_value);
					mismatch_count++;
				end
				if (out_data.last_of_run !== want.last_of_run) begin
					$display("%0t: last_of_run expected %0b got %0b", $time,
						want.last_of_run, out_data.last_of_run);
					mismatch_count++;
				end
				if (want.is_crc_byte)
					crc_bytes_checked++;
			end
			results_checked++;
		end
	end

	// watchdog on cycles with no traffic
	initial quiet_cycles = 0;
	always @(posedge clk) begin
		if ((in_valid && in_ready) || (out_valid && out_ready) || cfg_we)
			quiet_cycles <= 0;
		else
			quiet_cycles <= quiet_cycles + 1;
		if (quiet_cycles == STALL_LIMIT) begin
			$display("%0t: timeout, no request moved for %0d cycles", $time, STALL_LIMIT);
			$display("CHECKS FAILED");
			$finish;
		end
	end

endmodule

/* sim.f */
src/nfccrc_pkg.sv
src/nfccrc_crc_unit.sv
src/nfccrc_out_seq.sv
src/nfc_rf_crc16_engine_core.sv
test/testbench.sv
